@@ rtl/pssl_pkg.sv @@
// ----------------------------------------------------------------------------
// pssl_pkg: shared types and constants of the pointer seen-set probe unit
// Item formats, status and function codes, hash constants and the state
// encodings of the front and back parts.
// ----------------------------------------------------------------------------
package pssl_pkg;

  // Table geometry and field widths.
  localparam int SLOTS_DEF   = 1024;
  localparam int KEY_W       = 64;
  localparam int SLOT_IDX_W  = 10;
  localparam int HOME_W      = 16;   // enough hash bits for the largest table
  localparam int QUEUE_DEPTH = 2;

  // Constants of the 64-bit finaliser.
  localparam logic [KEY_W-1:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int               MIX_SHIFT = 33;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_EXCLUDED = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_EXCL_A = 2'd0,
    CFG_EXCL_B = 2'd1,
    CFG_EXCL_C = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    func_t             func;
    logic [KEY_W-1:0]  key;
  } cmd_t;

  typedef struct packed {
    status_t                status;
    logic [SLOT_IDX_W-1:0]  slot_index;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
    logic [KEY_W-1:0] c;
  } excl_keys_t;

  // One classified item waiting between the front and the back.
  typedef struct packed {
    func_t              func;
    logic               excluded;
    logic [KEY_W-1:0]   key;
    logic [HOME_W-1:0]  home;
  } q_entry_t;

  // One word of the slot memory.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
  } ram_word_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_LOOKUP,
    B_PROBE
  } back_state_t;

endpackage

@@ rtl/pssl_ram.sv @@
// ----------------------------------------------------------------------------
// pssl_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pssl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pssl_front.sv @@
// ----------------------------------------------------------------------------
// pssl_front: item intake, exclusion check and key hashing
// Takes an item, compares it with the excluded keys and runs the 64-bit
// finaliser on a single 32x32 multiplier before handing the item on.
// ----------------------------------------------------------------------------
module pssl_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  pssl_pkg::cmd_t        cmd,
  input  logic                  hold,
  input  pssl_pkg::excl_keys_t  excl,
  input  logic                  q_full,
  output logic                  busy,
  output logic                  q_push,
  output pssl_pkg::q_entry_t    q_data
);

  localparam int KW = pssl_pkg::KEY_W;
  localparam int HW = KW / 2;

  pssl_pkg::front_state_t state, state_next;
  logic [1:0]    phase, phase_next;
  logic          round, round_next;
  logic [KW-1:0] v, v_next;
  logic [KW-1:0] acc, acc_next;
  logic [KW-1:0] prod, prod_next;
  logic [KW-1:0] key, key_next;
  pssl_pkg::func_t func, func_next;
  logic          excluded, excluded_next;

  logic [KW-1:0] mul_c;
  logic [HW-1:0] op_a, op_b;
  logic [KW-1:0] addend;
  logic [KW-1:0] acc_sum;
  logic          in_excl;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pssl_pkg::F_IDLE;
      phase <= 2'd0;
      round <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      round <= round_next;
    end
  end

  always_ff @(posedge clk) begin
    v        <= v_next;
    acc      <= acc_next;
    prod     <= prod_next;
    key      <= key_next;
    func     <= func_next;
    excluded <= excluded_next;
  end

  // Low 64 bits of v * c from three partial products.
  always_comb begin
    mul_c = round ? pssl_pkg::MIX_C2 : pssl_pkg::MIX_C1;
    case (phase)
      2'd0: begin
        op_a = v[HW-1:0];
        op_b = mul_c[HW-1:0];
      end
      2'd1: begin
        op_a = v[HW-1:0];
        op_b = mul_c[KW-1:HW];
      end
      default: begin
        op_a = v[KW-1:HW];
        op_b = mul_c[HW-1:0];
      end
    endcase
    addend  = (phase == 2'd1) ? prod : {prod[HW-1:0], {HW{1'b0}}};
    acc_sum = acc + addend;
    in_excl = (cmd.key == excl.a) || (cmd.key == excl.b) || (cmd.key == excl.c);
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    round_next    = round;
    v_next        = v;
    acc_next      = acc;
    prod_next     = {{HW{1'b0}}, op_a} * {{HW{1'b0}}, op_b};
    key_next      = key;
    func_next     = func;
    excluded_next = excluded;
    q_push        = 1'b0;
    busy          = hold || (state != pssl_pkg::F_IDLE);

    unique case (state)
      pssl_pkg::F_IDLE: begin
        if (start && !hold) begin
          key_next      = cmd.key;
          func_next     = cmd.func;
          excluded_next = in_excl;
          v_next        = cmd.key ^ (cmd.key >> pssl_pkg::MIX_SHIFT);
          acc_next      = '0;
          phase_next    = 2'd0;
          round_next    = 1'b0;
          if (cmd.func == pssl_pkg::FUNC_CLEAR || in_excl) begin
            state_next = pssl_pkg::F_PUSH;
          end else begin
            state_next = pssl_pkg::F_MUL;
          end
        end
      end
      pssl_pkg::F_MUL: begin
        phase_next = phase + 2'd1;
        if (phase != 2'd0) begin
          acc_next = acc_sum;
        end
        if (phase == 2'd3) begin
          v_next   = acc_sum ^ (acc_sum >> pssl_pkg::MIX_SHIFT);
          acc_next = '0;
          if (round) begin
            state_next = pssl_pkg::F_PUSH;
          end else begin
            round_next = 1'b1;
          end
        end
      end
      pssl_pkg::F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = pssl_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = pssl_pkg::F_IDLE;
      end
    endcase
  end

  always_comb begin
    q_data.func     = func;
    q_data.excluded = excluded;
    q_data.key      = key;
    q_data.home     = v[pssl_pkg::HOME_W-1:0];
  end

endmodule

@@ rtl/pssl_queue.sv @@
// ----------------------------------------------------------------------------
// pssl_queue: short item queue between front and back
// A small first-in first-out buffer in flip-flops with a count.
// ----------------------------------------------------------------------------
module pssl_queue #(
  parameter int DEPTH = pssl_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pssl_pkg::q_entry_t push_data,
  input  logic               pop,
  output pssl_pkg::q_entry_t pop_data,
  output logic               full,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pssl_pkg::q_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/pssl_back.sv @@
// ----------------------------------------------------------------------------
// pssl_back: table probe, insert and clear
// Walks the slot memory one slot a cycle from the home slot, inserts new
// keys under the load limit and sweeps the memory on clear and after reset.
// ----------------------------------------------------------------------------
module pssl_back #(
  parameter int SLOTS = pssl_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  pssl_pkg::q_entry_t q_data,
  output logic               q_pop,
  output logic               init_busy,
  output logic               done,
  output pssl_pkg::result_t  result
);

  localparam int AW = $clog2(SLOTS);
  localparam int KW = pssl_pkg::KEY_W;
  localparam int RW = $bits(pssl_pkg::ram_word_t);
  localparam logic [AW-1:0] LAST  = AW'(SLOTS - 1);
  localparam logic [AW-1:0] LIMIT = AW'((3 * SLOTS) / 4);

  pssl_pkg::back_state_t state, state_next;
  logic [AW-1:0] sweep, sweep_next;
  logic [AW-1:0] count, count_next;
  logic [AW-1:0] probe_cnt, probe_cnt_next;
  logic [AW-1:0] slot, slot_next;
  logic [KW-1:0] key, key_next;
  logic          done_next;
  pssl_pkg::result_t result_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  pssl_pkg::ram_word_t ram_wdata, ram_rdata;
  logic [RW-1:0] ram_rdata_raw;

  pssl_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = pssl_pkg::ram_word_t'(ram_rdata_raw);
  assign init_busy = (state == pssl_pkg::B_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pssl_pkg::B_INIT;
      sweep     <= '0;
      count     <= '0;
      probe_cnt <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      count     <= count_next;
      probe_cnt <= probe_cnt_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    slot   <= slot_next;
    key    <= key_next;
    result <= result_next;
  end

  always_comb begin
    state_next     = state;
    sweep_next     = sweep;
    count_next     = count;
    probe_cnt_next = probe_cnt;
    slot_next      = slot;
    key_next       = key;
    done_next      = 1'b0;
    result_next    = result;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = sweep;
    ram_wdata      = '0;
    ram_raddr      = slot;

    unique case (state)
      pssl_pkg::B_INIT,
      pssl_pkg::B_CLEAR: begin
        ram_we     = 1'b1;
        sweep_next = sweep + AW'(1);
        if (sweep == LAST) begin
          state_next = pssl_pkg::B_IDLE;
          if (state == pssl_pkg::B_CLEAR) begin
            count_next             = '0;
            done_next              = 1'b1;
            result_next.status     = pssl_pkg::ST_CLEARED;
            result_next.slot_index = '0;
          end
        end
      end
      pssl_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          key_next       = q_data.key;
          slot_next      = q_data.home[AW-1:0];
          probe_cnt_next = '0;
          if (q_data.func == pssl_pkg::FUNC_CLEAR) begin
            state_next = pssl_pkg::B_CLEAR;
          end else if (q_data.excluded) begin
            done_next              = 1'b1;
            result_next.status     = pssl_pkg::ST_EXCLUDED;
            result_next.slot_index = '0;
          end else begin
            state_next = pssl_pkg::B_LOOKUP;
          end
        end
      end
      pssl_pkg::B_LOOKUP: begin
        state_next = pssl_pkg::B_PROBE;
      end
      pssl_pkg::B_PROBE: begin
        // Read the following slot ahead so that a miss can move straight on to the next slot.
        ram_raddr = slot + AW'(1);
        if (!ram_rdata.valid) begin
          state_next = pssl_pkg::B_IDLE;
          done_next  = 1'b1;
          if (count >= LIMIT) begin
            result_next.status     = pssl_pkg::ST_FULL;
            result_next.slot_index = '0;
          end else begin
            ram_we                 = 1'b1;
            ram_waddr              = slot;
            ram_wdata.valid        = 1'b1;
            ram_wdata.key          = key;
            count_next             = count + AW'(1);
            result_next.status     = pssl_pkg::ST_NEW;
            result_next.slot_index = pssl_pkg::SLOT_IDX_W'(slot);
          end
        end else if (ram_rdata.key == key) begin
          state_next             = pssl_pkg::B_IDLE;
          done_next              = 1'b1;
          result_next.status     = pssl_pkg::ST_PRESENT;
          result_next.slot_index = pssl_pkg::SLOT_IDX_W'(slot);
        end else if (probe_cnt == LAST) begin
          state_next             = pssl_pkg::B_IDLE;
          done_next              = 1'b1;
          result_next.status     = pssl_pkg::ST_FULL;
          result_next.slot_index = '0;
        end else begin
          slot_next      = slot + AW'(1);
          probe_cnt_next = probe_cnt + AW'(1);
        end
      end
      default: begin
        state_next = pssl_pkg::B_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/pointer_seen_set_linear_probe_unit.sv @@
// ----------------------------------------------------------------------------
// pointer_seen_set_linear_probe_unit: visited-set engine for 64-bit keys
// A clear item reports once it has swept every slot of the table.
// Throughput: the front takes a new keyed item only after it has hashed and
// pushed the previous one, bound by the single 32x32 multiplier of the hash;
// it also waits while the queue is full. The back probes one slot per cycle.
// Reset: the slot memory is swept to empty, busy high meanwhile.
// Results are shown for one cycle on done and cannot be held off.
// ----------------------------------------------------------------------------
//
// Structure
//   The front takes an item, checks the key against the three excluded keys
//   and hashes it with the 64-bit finaliser. Each 64-bit multiply is built
//   from three 32x32 partial products on one shared multiplier, which the two
//   multiplies of the finaliser use in turn.
//   A two-entry queue holds classified items, so that the front can hash the
//   next key while the back is still probing or sweeping.
//   The back keeps the table in one memory whose words carry a valid mark and
//   the key. It reads the home slot and then one slot per cycle, always
//   reading the following slot ahead, until it meets an empty slot, the same
//   key or has probed every slot. A new key is written only while the entry
//   count is below three-quarters of the table; otherwise the item reports
//   full. A clear item, and reset, sweep every slot to empty one per cycle.
//
// Configuration
//   The three excluded keys are plain registers written through cfg_we,
//   cfg_index and cfg_data. An index beyond the three is ignored.
// ----------------------------------------------------------------------------
module pointer_seen_set_linear_probe_unit #(
  parameter int SLOTS       = pssl_pkg::SLOTS_DEF,
  parameter int QUEUE_DEPTH = pssl_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  pssl_pkg::cmd_t               cmd,
  output logic                         busy,
  output logic                         done,
  output pssl_pkg::result_t            result,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [pssl_pkg::KEY_W-1:0]   cfg_data
);

  pssl_pkg::excl_keys_t excl;
  pssl_pkg::q_entry_t   q_push_data;
  pssl_pkg::q_entry_t   q_pop_data;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic init_busy;

  // Configuration registers. The user must change them only while the block is idle,
  // so the front may compare against them directly; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      excl <= '0;
    end else if (cfg_we) begin
      unique case (pssl_pkg::cfg_idx_t'(cfg_index))
        pssl_pkg::CFG_EXCL_A: begin
          excl.a <= cfg_data;
        end
        pssl_pkg::CFG_EXCL_B: begin
          excl.b <= cfg_data;
        end
        pssl_pkg::CFG_EXCL_C: begin
          excl.c <= cfg_data;
        end
        default: begin
          excl <= excl;
        end
      endcase
    end
  end

  // Intake and hashing. It holds off new items during the reset sweep.
  pssl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .hold   (init_busy),
    .excl   (excl),
    .q_full (q_full),
    .busy   (busy),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  pssl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Probing, insertion and clearing over the slot memory.
  pssl_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .done      (done),
    .result    (result)
  );

  // No result may appear while the table is still being swept after reset.
  assert property (@(posedge clk) disable iff (rst) init_busy |-> !done)
    else $error("result reported during the reset sweep");

  // A taken item must keep the front busy in the following cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("front idle straight after taking an item");

  // The front must never push into a full queue.
  assert property (@(posedge clk) disable iff (rst) !(q_push && q_full))
    else $error("item pushed into a full queue");

endmodule
